[hw/rtl/shell_sort_engine_macros.svh]
// ----------------------------------------------------------------------------
// shell_sort_engine assertion macros
// concurrent assertion shorthands used by the checker file sse_checker
// ----------------------------------------------------------------------------
`ifndef SHELL_SORT_ENGINE_MACROS_SVH
`define SHELL_SORT_ENGINE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sse_pkg.sv]
// ----------------------------------------------------------------------------
// sse_pkg
// shared types, register codes and gap sequence tables of the sort engine
// ----------------------------------------------------------------------------
package sse_pkg;

    // gaps and sort indices never exceed 64
    localparam int GAP_W     = 7;
    localparam int GAP_IDX_W = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [1:0] t_gap_seq;

    localparam t_gap_seq GAP_PRIME    = 2'd0;
    localparam t_gap_seq GAP_KNUTH    = 2'd1;
    localparam t_gap_seq GAP_MERSENNE = 2'd2;
    localparam t_gap_seq GAP_SQUARE   = 2'd3;

    localparam t_gap_seq GAP_SEQ_RESET = GAP_KNUTH;

    // register index (byte address bits above the word offset)
    localparam logic [0:0] REG_GAP_SEQ = 1'b0;

    // threshold that no set size reaches
    localparam logic [GAP_W-1:0] GAP_NEVER = 7'd127;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_set;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic             start;
        t_gap_seq         gap_seq;
        logic [GAP_W-1:0] n;
    } t_sort_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sort_sts;

    // gap at position k of a sequence, smallest first
    function automatic logic [GAP_W-1:0] gap_value(t_gap_seq seq, logic [GAP_IDX_W-1:0] k);
        logic [GAP_W-1:0] g;
        g = 7'd1;
        case (seq)
            GAP_PRIME: begin
                case (k)
                    3'd1:    g = 7'd5;
                    3'd2:    g = 7'd13;
                    3'd3:    g = 7'd31;
                    default: g = 7'd1;
                endcase
            end
            GAP_KNUTH: begin
                case (k)
                    3'd1:    g = 7'd4;
                    3'd2:    g = 7'd13;
                    3'd3:    g = 7'd40;
                    default: g = 7'd1;
                endcase
            end
            GAP_MERSENNE: begin
                case (k)
                    3'd1:    g = 7'd3;
                    3'd2:    g = 7'd7;
                    3'd3:    g = 7'd15;
                    3'd4:    g = 7'd31;
                    3'd5:    g = 7'd63;
                    default: g = 7'd1;
                endcase
            end
            default: begin
                case (k)
                    3'd1:    g = 7'd4;
                    3'd2:    g = 7'd9;
                    3'd3:    g = 7'd16;
                    3'd4:    g = 7'd25;
                    3'd5:    g = 7'd36;
                    3'd6:    g = 7'd49;
                    3'd7:    g = 7'd64;
                    default: g = 7'd1;
                endcase
            end
        endcase
        return g;
    endfunction

    // set size above which position k+1 of a sequence is used
    function automatic logic [GAP_W-1:0] gap_limit(t_gap_seq seq, logic [GAP_IDX_W-1:0] k);
        logic [GAP_W-1:0] t;
        t = GAP_NEVER;
        case (seq)
            GAP_PRIME: begin
                case (k)
                    3'd0:    t = 7'd17;
                    3'd1:    t = 7'd41;
                    default: t = GAP_NEVER;
                endcase
            end
            GAP_KNUTH: begin
                case (k)
                    3'd0:    t = 7'd3;
                    3'd1:    t = 7'd12;
                    3'd2:    t = 7'd39;
                    default: t = GAP_NEVER;
                endcase
            end
            GAP_MERSENNE: begin
                case (k)
                    3'd0:    t = 7'd2;
                    3'd1:    t = 7'd6;
                    3'd2:    t = 7'd14;
                    3'd3:    t = 7'd30;
                    3'd4:    t = 7'd62;
                    default: t = GAP_NEVER;
                endcase
            end
            default: begin
                case (k)
                    3'd0:    t = 7'd1;
                    3'd1:    t = 7'd4;
                    3'd2:    t = 7'd9;
                    3'd3:    t = 7'd16;
                    3'd4:    t = 7'd25;
                    3'd5:    t = 7'd36;
                    3'd6:    t = 7'd49;
                    default: t = GAP_NEVER;
                endcase
            end
        endcase
        return t;
    endfunction

    // position of the first (largest) gap for a set of n entries
    function automatic logic [GAP_IDX_W-1:0] gap_start(t_gap_seq seq, logic [GAP_W-1:0] n);
        logic [GAP_IDX_W-1:0] s;
        s = '0;
        for (int k = 0; k < 7; k++) begin
            s = s + GAP_IDX_W'(n > gap_limit(seq, GAP_IDX_W'(k)));
        end
        return s;
    endfunction

endpackage

[hw/rtl/sse_store.sv]
// ----------------------------------------------------------------------------
// sse_store
// element memory, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module sse_store #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 64,
    parameter int ADDR_W     = 6
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[hw/rtl/sse_sorter.sv]
// ----------------------------------------------------------------------------
// sse_sorter
// pass sequencer: gapped insertion passes over the element memory
// ----------------------------------------------------------------------------
module sse_sorter #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sse_pkg::t_sort_cmd      i_cmd,
    output sse_pkg::t_sort_sts      o_sts,
    output logic                    o_rd_en,
    output logic [ADDR_W-1:0]       o_rd_addr,
    input  logic [DATA_WIDTH-1:0]   i_rd_data,
    output logic                    o_wr_en,
    output logic [ADDR_W-1:0]       o_wr_addr,
    output logic [DATA_WIDTH-1:0]   o_wr_data
);

    import sse_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_KEY,
        ST_CMP,
        ST_PLACE
    } t_state;

    t_state                 r_state;
    t_gap_seq               r_seq;
    logic [GAP_W-1:0]       r_n;
    logic [GAP_IDX_W-1:0]   r_k;
    logic [GAP_W-1:0]       r_gap;
    logic [GAP_W-1:0]       r_i;
    logic [GAP_W-1:0]       r_j;
    logic [DATA_WIDTH-1:0]  r_key;
    logic                   r_done;

    logic [GAP_IDX_W-1:0]   start_k;
    logic [GAP_W-1:0]       start_gap;
    logic [GAP_IDX_W-1:0]   k_dn;
    logic [GAP_W-1:0]       gap_dn;
    logic [GAP_W-1:0]       jg;
    logic [GAP_W-1:0]       jgg;
    logic                   key_less;
    logic                   more_left;

    always_comb begin
        start_k   = gap_start(i_cmd.gap_seq, i_cmd.n);
        start_gap = gap_value(i_cmd.gap_seq, start_k);
        k_dn      = r_k - 1'b1;
        gap_dn    = gap_value(r_seq, k_dn);
        jg        = r_j - r_gap;
        jgg       = jg - r_gap;
        key_less  = $signed(r_key) < $signed(i_rd_data);
        more_left = (jg >= r_gap);
    end

    // memory strobes
    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_i[ADDR_W-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_j[ADDR_W-1:0];
        o_wr_data = r_key;
        unique case (r_state)
            ST_PASS: begin
                o_rd_en = (r_i < r_n);
            end
            ST_KEY: begin
                o_rd_en   = 1'b1;
                o_rd_addr = jg[ADDR_W-1:0];
            end
            ST_CMP: begin
                o_wr_en   = 1'b1;
                o_rd_en   = key_less && more_left;
                o_rd_addr = jgg[ADDR_W-1:0];
                o_wr_data = key_less ? i_rd_data : r_key;
            end
            ST_PLACE: begin
                o_wr_en = 1'b1;
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd.start) begin
                        r_seq   <= i_cmd.gap_seq;
                        r_n     <= i_cmd.n;
                        r_k     <= start_k;
                        r_gap   <= start_gap;
                        r_i     <= start_gap;
                        r_state <= ST_PASS;
                    end
                end
                ST_PASS: begin
                    if (r_i >= r_n) begin
                        if (r_k == '0) begin
                            r_done  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k   <= k_dn;
                            r_gap <= gap_dn;
                            r_i   <= gap_dn;
                        end
                    end else begin
                        r_j     <= r_i;
                        r_state <= ST_KEY;
                    end
                end
                ST_KEY: begin
                    r_key   <= i_rd_data;
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (key_less) begin
                        // shift the larger element up by one gap
                        r_j <= jg;
                        if (!more_left) begin
                            r_state <= ST_PLACE;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_PASS;
                    end
                end
                ST_PLACE: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= ST_PASS;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_sts.busy = (r_state != ST_IDLE);
    assign o_sts.done = r_done;

endmodule

[hw/rtl/shell_sort_engine.sv]
// ----------------------------------------------------------------------------
// shell_sort_engine
// collects a set of signed values, shell sorts it in memory, emits it ascending
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_ready      i_in_item  (value, last_item)
//  out       output     o_out_valid / i_out_ready    o_out_item (sorted_value,
//                                                    end_of_set, overflow)
//  cfg       input      psel/penable/pwrite, pready  paddr, pwdata, prdata
//
//  loading takes one cycle per input transfer; the item marked last starts the sort
//  sorting walks the single element memory pass by pass over the chosen gap sequence;
//  each key is read, larger elements a gap below shift up, then the key is placed
//  results leave one by one: a read waits for the previous read data and a free output
//  synchronous active-low reset clears control state; the memory needs no clearing
//  input is not accepted while sorting or emitting; output stalls hold the result
// ----------------------------------------------------------------------------
module shell_sort_engine #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  sse_pkg::t_in_item                   i_in_item,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    // output channel
    output sse_pkg::t_out_item                  o_out_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sse_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sse_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [sse_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    import sse_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    // stored values keep at most 32 significant bits
    localparam int LOAD_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    t_state              r_state;
    t_gap_seq            r_gap_seq;
    logic [CNT_W-1:0]    r_count;
    logic                r_ovf;
    logic                r_start;
    logic [CNT_W-1:0]    r_ek;
    logic                r_pend;
    logic                r_pend_last;
    logic                r_out_valid;
    t_out_item           r_out;

    t_sort_cmd           sort_cmd;
    t_sort_sts           sort_sts;

    logic                s_rd_en;
    logic [ADDR_W-1:0]   s_rd_addr;
    logic                s_wr_en;
    logic [ADDR_W-1:0]   s_wr_addr;
    logic [DATA_WIDTH-1:0] s_wr_data;

    logic                m_rd_en;
    logic [ADDR_W-1:0]   m_rd_addr;
    logic                m_wr_en;
    logic [ADDR_W-1:0]   m_wr_addr;
    logic [DATA_WIDTH-1:0] m_wr_data;
    logic [DATA_WIDTH-1:0] m_rd_data;

    logic                in_xfer;
    logic                out_xfer;
    logic                has_room;
    logic                emit_issue;
    logic                cfg_write;
    logic signed [LOAD_W-1:0] load_low;
    logic signed [LOAD_W-1:0] out_low;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[CFG_ADDR_W-1:2] == REG_GAP_SEQ) begin
            prdata = {{(CFG_DATA_W-2){1'b0}}, r_gap_seq};
        end
    end

    // ---------------- handshakes ----------------
    assign o_in_ready  = (r_state == ST_LOAD);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_xfer    = r_out_valid && i_out_ready;
    assign has_room    = (r_count < CNT_W'(MAX_ITEMS));

    // next result read: only when the output register will be free to catch it
    assign emit_issue = (r_state == ST_EMIT) && (r_ek < r_count) && !r_pend
                        && (!r_out_valid || i_out_ready);

    // low bits of the value, sign extended to the storage width on load and to 32 bits on output
    assign load_low = i_in_item.value[LOAD_W-1:0];
    assign out_low  = m_rd_data[LOAD_W-1:0];

    // ---------------- memory port sharing ----------------
    always_comb begin
        if (sort_sts.busy) begin
            m_wr_en   = s_wr_en;
            m_wr_addr = s_wr_addr;
            m_wr_data = s_wr_data;
            m_rd_en   = s_rd_en;
            m_rd_addr = s_rd_addr;
        end else begin
            m_wr_en   = in_xfer && has_room;
            m_wr_addr = r_count[ADDR_W-1:0];
            m_wr_data = DATA_WIDTH'(load_low);
            m_rd_en   = emit_issue;
            m_rd_addr = r_ek[ADDR_W-1:0];
        end
    end

    assign sort_cmd.start   = r_start;
    assign sort_cmd.gap_seq = r_gap_seq;
    assign sort_cmd.n       = GAP_W'(r_count);

    sse_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (MAX_ITEMS),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (m_wr_en),
        .i_wr_addr (m_wr_addr),
        .i_wr_data (m_wr_data),
        .i_rd_en   (m_rd_en),
        .i_rd_addr (m_rd_addr),
        .o_rd_data (m_rd_data)
    );

    sse_sorter #(
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_sorter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (sort_cmd),
        .o_sts     (sort_sts),
        .o_rd_en   (s_rd_en),
        .o_rd_addr (s_rd_addr),
        .i_rd_data (m_rd_data),
        .o_wr_en   (s_wr_en),
        .o_wr_addr (s_wr_addr),
        .o_wr_data (s_wr_data)
    );

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_gap_seq   <= GAP_SEQ_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_start     <= 1'b0;
            r_ek        <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;

            if (cfg_write && (paddr[CFG_ADDR_W-1:2] == REG_GAP_SEQ)) begin
                r_gap_seq <= pwdata[1:0];
            end

            unique case (r_state)
                ST_LOAD: begin
                    if (in_xfer) begin
                        if (has_room) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            // store full: value dropped, set is flagged
                            r_ovf <= 1'b1;
                        end
                        if (i_in_item.last_item) begin
                            r_start <= 1'b1;
                            r_state <= ST_SORT;
                        end
                    end
                end
                ST_SORT: begin
                    if (sort_sts.done) begin
                        r_ek    <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_xfer && r_out.end_of_set) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase

            // output register: r_pend flags the cycle after the read, when the read data is valid
            r_pend <= emit_issue;
            if (emit_issue) begin
                r_ek        <= r_ek + 1'b1;
                r_pend_last <= (r_ek + 1'b1 == r_count);
            end
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out.sorted_value <= 32'(out_low);
            r_out.end_of_set   <= r_pend_last;
            r_out.overflow     <= r_ovf;
        end
    end

endmodule

[hw/rtl/sse_checker.sv]
// ----------------------------------------------------------------------------
// sse_checker
// port level checks of the sort engine, bound to the top level
// ----------------------------------------------------------------------------
`include "shell_sort_engine_macros.svh"

module sse_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sse_pkg::t_in_item                   i_in_item,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  sse_pkg::t_out_item                  o_out_item,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready
);

    // a stalled result holds
    `SSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "stalled result changed")

    // no loading while a result is offered
    `SSE_ASSERT_SAME(a_no_load_emit, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input ready while emitting")

    // the last item of a set closes the input until the set is emitted
    `SSE_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_item.last_item, !o_in_ready && !o_out_valid, "input still open after last item")

    // after the final result the block is back to loading
    `SSE_ASSERT_NEXT(a_end_reload, i_clk, i_rst_n, o_out_valid && i_out_ready && o_out_item.end_of_set, o_in_ready && !o_out_valid, "not reloading after end of set")

endmodule

bind shell_sort_engine sse_checker u_sse_checker (.*);
